>>> rtl/core/frs_pkg.sv
// Shared types and constants for the filled shape rasterizer.
// No dependencies; used by every module of the block by scoped names.
package frs_pkg;

  // Scan coordinates: 13-bit signed covers pos +/- size for 12-bit pos, 11-bit size.
  localparam int unsigned CoordW    = 13;
  localparam int unsigned PosW      = 12;
  localparam int unsigned SizeW     = 11;
  localparam int unsigned RadSqW    = 22;
  localparam int unsigned ColourW   = 12;
  localparam int unsigned AddrW     = 30;
  localparam int unsigned PixelW    = 24;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [AddrW-1:0] FrameBaseReset = 30'h2000_0000;

  // Register index taken from paddr[2] (word address).
  localparam logic RegFrameBase = 1'b0;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  // One scan position on its way to the pixel stage.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [PosW-1:0]   cx;
    logic signed [PosW-1:0]   cy;
    logic [RadSqW-1:0]        rad_sq;
    logic                     circle;
    logic [ColourW-1:0]       colour;
    logic                     last;
  } scan_pos_t;

endpackage

>>> rtl/core/frs_cfg_regs.sv
// APB register file of the filled shape rasterizer: the frame base word address.
// Depends on frs_pkg.
module frs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frs_pkg::ApbAddrW-1:0]  paddr,
  input  logic [frs_pkg::ApbDataW-1:0]  pwdata,
  output logic [frs_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output logic [frs_pkg::AddrW-1:0]     frame_base_o
);

  logic [frs_pkg::AddrW-1:0] frame_base_q, frame_base_d;
  logic                      wr_en;

  assign wr_en = psel & penable & pwrite & (paddr[2] == frs_pkg::RegFrameBase);

  always_comb begin
    frame_base_d = frame_base_q;
    if (wr_en) begin
      frame_base_d = pwdata[frs_pkg::AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= frs_pkg::FrameBaseReset;
    end else begin
      frame_base_q <= frame_base_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == frs_pkg::RegFrameBase) begin
      prdata = {{(frs_pkg::ApbDataW - frs_pkg::AddrW){1'b0}}, frame_base_q};
    end
  end

  assign pready       = 1'b1;
  assign frame_base_o = frame_base_q;

endmodule

>>> rtl/core/frs_scanner.sv
// Shape loader and scan walker: holds the current shape, steps x outer / y inner
// and registers one scan position per tick on a loaded shape. Depends on frs_pkg.
module frs_scanner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic                           shape_is_circle_i,
  input  logic signed [frs_pkg::PosW-1:0] pos_x_i,
  input  logic signed [frs_pkg::PosW-1:0] pos_y_i,
  input  logic [frs_pkg::SizeW-1:0]      size_a_i,
  input  logic [frs_pkg::SizeW-1:0]      size_b_i,
  input  logic [3:0]                     red_i,
  input  logic [3:0]                     green_i,
  input  logic [3:0]                     blue_i,
  output logic                           pos_valid_o,
  input  logic                           pos_ready_i,
  output frs_pkg::scan_pos_t             pos_o
);

  localparam int unsigned CW = frs_pkg::CoordW;

  logic                          busy_q, busy_d;
  logic                          circle_q, circle_d;
  logic signed [CW-1:0]          scan_x_q, scan_x_d;
  logic signed [CW-1:0]          scan_y_q, scan_y_d;
  logic signed [CW-1:0]          first_y_q, first_y_d;
  logic signed [CW-1:0]          end_x_q, end_x_d;
  logic signed [CW-1:0]          end_y_q, end_y_d;
  logic signed [frs_pkg::PosW-1:0] cx_q, cx_d;
  logic signed [frs_pkg::PosW-1:0] cy_q, cy_d;
  logic [frs_pkg::RadSqW-1:0]    rad_sq_q, rad_sq_d;
  logic [frs_pkg::ColourW-1:0]   colour_q, colour_d;

  logic                          pos_valid_q, pos_valid_d;
  frs_pkg::scan_pos_t            pos_q, pos_d;

  logic                          accept, is_tick, emit;
  logic signed [CW-1:0]          px, py, sa, sb, y_inc, x_inc;

  assign in_ready_o = !pos_valid_q || pos_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign is_tick    = (kind_i == frs_pkg::KIND_TICK);
  assign emit       = accept & is_tick & busy_q;

  assign px    = {pos_x_i[frs_pkg::PosW-1], pos_x_i};
  assign py    = {pos_y_i[frs_pkg::PosW-1], pos_y_i};
  assign sa    = {{(CW - frs_pkg::SizeW){1'b0}}, size_a_i};
  assign sb    = {{(CW - frs_pkg::SizeW){1'b0}}, size_b_i};
  assign y_inc = scan_y_q + CW'(1);
  assign x_inc = scan_x_q + CW'(1);

  // Shape state update
  always_comb begin
    busy_d    = busy_q;
    circle_d  = circle_q;
    scan_x_d  = scan_x_q;
    scan_y_d  = scan_y_q;
    first_y_d = first_y_q;
    end_x_d   = end_x_q;
    end_y_d   = end_y_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    rad_sq_d  = rad_sq_q;
    colour_d  = colour_q;
    if (accept && !is_tick) begin
      circle_d = shape_is_circle_i;
      colour_d = {red_i, green_i, blue_i};
      cx_d     = pos_x_i;
      cy_d     = pos_y_i;
      if (shape_is_circle_i) begin
        rad_sq_d  = frs_pkg::RadSqW'(size_a_i) * frs_pkg::RadSqW'(size_a_i);
        scan_x_d  = px - sa;
        first_y_d = py - sa;
        scan_y_d  = py - sa;
        end_x_d   = px + sa;
        end_y_d   = py + sa;
        busy_d    = (size_a_i != '0);
      end else begin
        rad_sq_d  = '0;
        scan_x_d  = px;
        first_y_d = py;
        scan_y_d  = py;
        end_x_d   = px + sa;
        end_y_d   = py + sb;
        busy_d    = (size_a_i != '0) && (size_b_i != '0);
      end
    end else if (emit) begin
      if (y_inc >= end_y_q) begin
        scan_y_d = first_y_q;
        scan_x_d = x_inc;
        if (x_inc >= end_x_q) begin
          busy_d = 1'b0;
        end
      end else begin
        scan_y_d = y_inc;
      end
    end
  end

  // Position register toward the pixel stage
  always_comb begin
    pos_valid_d = pos_valid_q;
    pos_d       = pos_q;
    if (in_ready_o) begin
      pos_valid_d = emit;
    end
    if (emit) begin
      pos_d.x      = scan_x_q;
      pos_d.y      = scan_y_q;
      pos_d.cx     = cx_q;
      pos_d.cy     = cy_q;
      pos_d.rad_sq = rad_sq_q;
      pos_d.circle = circle_q;
      pos_d.colour = colour_q;
      pos_d.last   = (scan_x_q == end_x_q - CW'(1)) && (scan_y_q == end_y_q - CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      circle_q    <= 1'b0;
      scan_x_q    <= '0;
      scan_y_q    <= '0;
      first_y_q   <= '0;
      end_x_q     <= '0;
      end_y_q     <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      rad_sq_q    <= '0;
      colour_q    <= '0;
      pos_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      circle_q    <= circle_d;
      scan_x_q    <= scan_x_d;
      scan_y_q    <= scan_y_d;
      first_y_q   <= first_y_d;
      end_x_q     <= end_x_d;
      end_y_q     <= end_y_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      rad_sq_q    <= rad_sq_d;
      colour_q    <= colour_d;
      pos_valid_q <= pos_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  assign pos_valid_o = pos_valid_q;
  assign pos_o       = pos_q;

endmodule

>>> rtl/core/frs_pixel.sv
// Pixel stage: circle inside test, screen clip, address and colour packing into
// the result register. Depends on frs_pkg.
module frs_pixel #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480,
  parameter int unsigned ROW_STRIDE    = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pos_valid_i,
  output logic                         pos_ready_o,
  input  frs_pkg::scan_pos_t           pos_i,
  input  logic [frs_pkg::AddrW-1:0]    frame_base_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         write_enable_o,
  output logic [frs_pkg::AddrW-1:0]    word_address_o,
  output logic [frs_pkg::PixelW-1:0]   pixel_word_o,
  output logic                         last_o
);

  localparam int unsigned CW = frs_pkg::CoordW;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned AW = frs_pkg::AddrW;

  logic signed [DW-1:0]       dx, dy;
  logic [2*DW-1:0]            sq_x, sq_y;
  logic [2*DW:0]              dist_sq;
  logic                       in_shape, on_screen, we;
  logic [AW-1:0]              addr;
  logic [frs_pkg::PixelW-1:0] pixel;

  logic                       out_valid_q, out_valid_d;
  logic                       we_q, we_d;
  logic [AW-1:0]              addr_q, addr_d;
  logic [frs_pkg::PixelW-1:0] pixel_q, pixel_d;
  logic                       last_q, last_d;

  assign pos_ready_o = !out_valid_q || out_ready_i;

  assign dx = {{2{pos_i.cx[frs_pkg::PosW-1]}}, pos_i.cx} - {pos_i.x[CW-1], pos_i.x};
  assign dy = {{2{pos_i.cy[frs_pkg::PosW-1]}}, pos_i.cy} - {pos_i.y[CW-1], pos_i.y};
  // Sign-extend before squaring so the product keeps its full width
  assign sq_x    = $unsigned((2*DW)'(dx) * (2*DW)'(dx));
  assign sq_y    = $unsigned((2*DW)'(dy) * (2*DW)'(dy));
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign in_shape = !pos_i.circle ||
                    (dist_sq <= {{(2*DW + 1 - frs_pkg::RadSqW){1'b0}}, pos_i.rad_sq});

  // Nonnegative coordinates compare as unsigned against the screen size
  assign on_screen = !pos_i.x[CW-1] && ($unsigned(pos_i.x) < CW'(SCREEN_WIDTH)) &&
                     !pos_i.y[CW-1] && ($unsigned(pos_i.y) < CW'(SCREEN_HEIGHT));
  assign we = in_shape && on_screen;

  assign addr  = frame_base_i
               + AW'(AW'(ROW_STRIDE) * {{(AW - CW + 1){1'b0}}, pos_i.y[CW-2:0]})
               + {{(AW - CW + 1){1'b0}}, pos_i.x[CW-2:0]};
  assign pixel = {pos_i.colour[11:8], 4'h0, pos_i.colour[7:4], 4'h0, pos_i.colour[3:0], 4'h0};

  always_comb begin
    out_valid_d = out_valid_q;
    we_d        = we_q;
    addr_d      = addr_q;
    pixel_d     = pixel_q;
    last_d      = last_q;
    if (pos_ready_o) begin
      out_valid_d = pos_valid_i;
    end
    if (pos_ready_o && pos_valid_i) begin
      we_d    = we;
      addr_d  = we ? addr : '0;
      pixel_d = we ? pixel : '0;
      last_d  = pos_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    we_q    <= we_d;
    addr_q  <= addr_d;
    pixel_q <= pixel_d;
    last_q  <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign word_address_o = addr_q;
  assign pixel_word_o   = pixel_q;
  assign last_o         = last_q;

endmodule

>>> rtl/core/filled_shape_rasterizer_unit.sv
// Filled rectangle / circle rasterizer. A start transaction (kind 0) loads a shape
// and produces no result; each tick transaction (kind 1) on a loaded shape walks one
// scan position (x outer, y inner) and produces one result transaction. Throughput is
// one transaction per cycle while the output does not stall; a tick's result passes
// through the scan position register and then the result register. Backpressure on the
// output stalls the input once both registers hold data. Frame base is set over APB.
// Depends on frs_pkg, frs_cfg_regs, frs_scanner and frs_pixel.
module filled_shape_rasterizer_unit #(
  parameter int unsigned SCREEN_WIDTH  = 640,
  parameter int unsigned SCREEN_HEIGHT = 480,
  parameter int unsigned ROW_STRIDE    = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [frs_pkg::ApbAddrW-1:0]    paddr,
  input  logic [frs_pkg::ApbDataW-1:0]    pwdata,
  output logic [frs_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic                            shape_is_circle_i,
  input  logic signed [frs_pkg::PosW-1:0] pos_x_i,
  input  logic signed [frs_pkg::PosW-1:0] pos_y_i,
  input  logic [frs_pkg::SizeW-1:0]       size_a_i,
  input  logic [frs_pkg::SizeW-1:0]       size_b_i,
  input  logic [3:0]                      red_i,
  input  logic [3:0]                      green_i,
  input  logic [3:0]                      blue_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            write_enable_o,
  output logic [frs_pkg::AddrW-1:0]       word_address_o,
  output logic [frs_pkg::PixelW-1:0]      pixel_word_o,
  output logic                            last_o
);

  logic [frs_pkg::AddrW-1:0] frame_base;
  logic                      pos_valid, pos_ready;
  frs_pkg::scan_pos_t        pos;

  frs_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_base_o (frame_base)
  );

  frs_scanner u_scanner (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .shape_is_circle_i (shape_is_circle_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .size_a_i          (size_a_i),
    .size_b_i          (size_b_i),
    .red_i             (red_i),
    .green_i           (green_i),
    .blue_i            (blue_i),
    .pos_valid_o       (pos_valid),
    .pos_ready_i       (pos_ready),
    .pos_o             (pos)
  );

  frs_pixel #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ROW_STRIDE    (ROW_STRIDE)
  ) u_pixel (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pos_valid_i    (pos_valid),
    .pos_ready_o    (pos_ready),
    .pos_i          (pos),
    .frame_base_i   (frame_base),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_enable_o (write_enable_o),
    .word_address_o (word_address_o),
    .pixel_word_o   (pixel_word_o),
    .last_o         (last_o)
  );

endmodule

>>> tb/sv/filled_shape_rasterizer_unit_test.sv
// Self-checking testbench for filled_shape_rasterizer_unit: rectangle/circle scan results
// are predicted by a scoreboard class and compared per field under random flow control.
// Depends on frs_pkg and the filled_shape_rasterizer_unit RTL.

localparam int ScreenWidth  = 640;
localparam int ScreenHeight = 480;
localparam int RowStride    = 1024;

typedef struct {
  frs_pkg::kind_e                  kind;
  logic                            circle;
  logic signed [frs_pkg::PosW-1:0] pos_x;
  logic signed [frs_pkg::PosW-1:0] pos_y;
  logic [frs_pkg::SizeW-1:0]       size_a;
  logic [frs_pkg::SizeW-1:0]       size_b;
  logic [3:0]                      red;
  logic [3:0]                      green;
  logic [3:0]                      blue;
} shape_item_t;

typedef struct {
  logic                         we;
  logic [frs_pkg::AddrW-1:0]    addr;
  logic [frs_pkg::PixelW-1:0]   pixel;
  logic                         last;
} pixel_write_t;

class raster_scoreboard;
  logic [frs_pkg::AddrW-1:0] frame_base;
  bit                        busy;
  bit                        circle;
  int                        scan_x;
  int                        scan_y;
  int                        first_y;
  int                        end_x;
  int                        end_y;
  int                        centre_x;
  int                        centre_y;
  int                        rad_sq;
  logic [frs_pkg::ColourW-1:0] colour;
  pixel_write_t              pending_writes[$];
  int                        errors;

  function new();
    frame_base = frs_pkg::FrameBaseReset;
    busy = 1'b0;
    circle = 1'b0;
    scan_x = 0;
    scan_y = 0;
    first_y = 0;
    end_x = 0;
    end_y = 0;
    centre_x = 0;
    centre_y = 0;
    rad_sq = 0;
    colour = '0;
    errors = 0;
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < 30) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    end
    errors++;
  endtask

  // Updates the shape state for one accepted transaction; returns 1 if it yields a result.
  function bit note_item(shape_item_t it);
    int px;
    int py;
    int a;
    int b;
    int x;
    int y;
    int dx;
    int dy;
    bit in_shape;
    bit on_screen;
    logic [frs_pkg::AddrW-1:0] offset;
    pixel_write_t wr;
    if (it.kind == frs_pkg::KIND_START) begin
      px = it.pos_x;
      py = it.pos_y;
      a = it.size_a;
      b = it.size_b;
      circle = it.circle;
      colour = {it.red, it.green, it.blue};
      centre_x = px;
      centre_y = py;
      if (circle) begin
        rad_sq = a * a;
        scan_x = px - a;
        first_y = py - a;
        end_x = px + a;
        end_y = py + a;
        busy = (a != 0);
      end else begin
        rad_sq = 0;
        scan_x = px;
        first_y = py;
        end_x = px + a;
        end_y = py + b;
        busy = (a != 0) && (b != 0);
      end
      scan_y = first_y;
      return 1'b0;
    end
    if (!busy) return 1'b0;

    x = scan_x;
    y = scan_y;
    in_shape = 1'b1;
    if (circle) begin
      dx = centre_x - x;
      dy = centre_y - y;
      in_shape = (dx * dx + dy * dy) <= rad_sq;
    end
    on_screen = x >= 0 && x < ScreenWidth && y >= 0 && y < ScreenHeight;
    wr.we = in_shape && on_screen;
    wr.addr = '0;
    wr.pixel = '0;
    if (wr.we) begin
      offset = frs_pkg::AddrW'(RowStride * y + x);
      wr.addr = frame_base + offset;
      wr.pixel = {colour[11:8], 4'h0, colour[7:4], 4'h0, colour[3:0], 4'h0};
    end
    wr.last = (x == end_x - 1) && (y == end_y - 1);
    pending_writes.push_back(wr);

    scan_y = y + 1;
    if (scan_y >= end_y) begin
      scan_y = first_y;
      scan_x = x + 1;
      if (scan_x >= end_x) busy = 1'b0;
    end
    return 1'b1;
  endfunction

  task check_write(pixel_write_t got);
    pixel_write_t want;
    if (pending_writes.size() == 0) begin
      report_mismatch("result with nothing pending, address", got.addr, 0);
      return;
    end
    want = pending_writes.pop_front();
    if (got.we !== want.we) report_mismatch("write_enable", got.we, want.we);
    if (got.addr !== want.addr) report_mismatch("word_address", got.addr, want.addr);
    if (got.pixel !== want.pixel) report_mismatch("pixel_word", got.pixel, want.pixel);
    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
  endtask
endclass

module filled_shape_rasterizer_unit_test;
  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 6;
  localparam int HoldOffCycles = 300;
  localparam int PhaseItems    = 170;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_MASK
  } ready_mode_e;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [frs_pkg::ApbAddrW-1:0]    paddr = '0;
  logic [frs_pkg::ApbDataW-1:0]    pwdata = '0;
  logic [frs_pkg::ApbDataW-1:0]    prdata;
  logic                            pready;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic                            kind_i = 1'b0;
  logic                            shape_is_circle_i = 1'b0;
  logic signed [frs_pkg::PosW-1:0] pos_x_i = '0;
  logic signed [frs_pkg::PosW-1:0] pos_y_i = '0;
  logic [frs_pkg::SizeW-1:0]       size_a_i = '0;
  logic [frs_pkg::SizeW-1:0]       size_b_i = '0;
  logic [3:0]                      red_i = '0;
  logic [3:0]                      green_i = '0;
  logic [3:0]                      blue_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic                            write_enable_o;
  logic [frs_pkg::AddrW-1:0]       word_address_o;
  logic [frs_pkg::PixelW-1:0]      pixel_word_o;
  logic                            last_o;

  raster_scoreboard sb;
  int burst_left = 0;
  int counted_items = 0;
  int idle_cycles = 0;
  bit hold_off_req = 1'b0;

  filled_shape_rasterizer_unit #(
    .SCREEN_WIDTH (ScreenWidth),
    .SCREEN_HEIGHT(ScreenHeight),
    .ROW_STRIDE   (RowStride)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .shape_is_circle_i(shape_is_circle_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .size_a_i         (size_a_i),
    .size_b_i         (size_b_i),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .write_enable_o   (write_enable_o),
    .word_address_o   (word_address_o),
    .pixel_word_o     (pixel_word_o),
    .last_o           (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side: stall patterns change at random; one long hold-off on request.
  initial begin : result_receiver
    ready_mode_e mode;
    int mode_left;
    int hold_left;
    logic [7:0] mask;
    mode = READY_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    mask = 8'hff;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HoldOffCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = ready_mode_e'($urandom_range(3));
          mode_left = $urandom_range(64, 1);
          mask = 8'($urandom);
        end
        mode_left--;
        case (mode)
          READY_ALWAYS: out_ready_i <= 1'b1;
          READY_COIN:   out_ready_i <= 1'($urandom_range(1));
          READY_SPARSE: out_ready_i <= ($urandom_range(3) == 0);
          default: begin
            out_ready_i <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_write_t got;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      got.we = write_enable_o;
      got.addr = word_address_o;
      got.pixel = pixel_word_o;
      got.last = last_o;
      sb.check_write(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL filled_shape_rasterizer_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic sender_pause(int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Offers one transaction, with bursts and gaps on the input side.
  task automatic offer(shape_item_t it);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(80, 40) : $urandom_range(16, 1);
      if ($urandom_range(3) != 0) sender_pause($urandom_range(8, 1));
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i <= it.kind;
    shape_is_circle_i <= it.circle;
    pos_x_i <= it.pos_x;
    pos_y_i <= it.pos_y;
    size_a_i <= it.size_a;
    size_b_i <= it.size_b;
    red_i <= it.red;
    green_i <= it.green;
    blue_i <= it.blue;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (sb.note_item(it) || it.kind == frs_pkg::KIND_START) counted_items++;
  endtask

  function automatic shape_item_t random_tick();
    shape_item_t it;
    it.kind = frs_pkg::KIND_TICK;
    it.circle = 1'($urandom);
    it.pos_x = frs_pkg::PosW'($urandom);
    it.pos_y = frs_pkg::PosW'($urandom);
    it.size_a = frs_pkg::SizeW'($urandom);
    it.size_b = frs_pkg::SizeW'($urandom);
    it.red = 4'($urandom);
    it.green = 4'($urandom);
    it.blue = 4'($urandom);
    return it;
  endfunction

  task automatic send_ticks(int n);
    repeat (n) offer(random_tick());
  endtask

  task automatic start_shape(bit circle, int px, int py, int a, int b,
                             logic [3:0] r, logic [3:0] g, logic [3:0] bl);
    shape_item_t it;
    it.kind = frs_pkg::KIND_START;
    it.circle = circle;
    it.pos_x = frs_pkg::PosW'(px);
    it.pos_y = frs_pkg::PosW'(py);
    it.size_a = frs_pkg::SizeW'(a);
    it.size_b = frs_pkg::SizeW'(b);
    it.red = r;
    it.green = g;
    it.blue = bl;
    offer(it);
  endtask

  // Mix of full range, around zero, around the screen edge and on screen.
  function automatic int pick_coord(int extent);
    int v;
    case ($urandom_range(4))
      0: v = $urandom_range(4095) - 2048;
      1: v = $urandom_range(12) - 6;
      2: v = extent + $urandom_range(8) - 6;
      default: v = $urandom_range(extent - 1);
    endcase
    return v;
  endfunction

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_writes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_frame_base(logic [frs_pkg::AddrW-1:0] base);
    logic [frs_pkg::ApbAddrW-1:0] addr;
    logic [1:0] junk;
    addr = {frs_pkg::RegFrameBase, 2'b00};
    junk = 2'($urandom);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {junk, base};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.frame_base = base;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== {2'b00, base}) sb.report_mismatch("frame base readback", prdata, base);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_phase(int target, bit with_hold_off);
    int first_count;
    int pick;
    int full;
    int a;
    int b;
    bit circle;
    first_count = counted_items;
    while (counted_items - first_count < target) begin
      if (with_hold_off && counted_items - first_count > target / 2) begin
        hold_off_req = 1'b1;
        with_hold_off = 1'b0;
      end
      pick = $urandom_range(99);
      if ($urandom_range(30) == 0) drain_results();
      circle = 1'($urandom);
      if (circle) begin
        a = $urandom_range(5, 1);
        b = $urandom;
        full = 4 * a * a;
      end else begin
        a = $urandom_range(8, 1);
        b = $urandom_range(8, 1);
        full = a * b;
      end
      if (pick < 70) begin
        start_shape(circle, pick_coord(ScreenWidth), pick_coord(ScreenHeight), a, b,
                    4'($urandom), 4'($urandom), 4'($urandom));
        send_ticks(full);
        if ($urandom_range(6) == 0) send_ticks(1);
      end else if (pick < 80) begin
        // abandoned part way by the next start
        start_shape(circle, pick_coord(ScreenWidth), pick_coord(ScreenHeight), a, b,
                    4'($urandom), 4'($urandom), 4'($urandom));
        send_ticks($urandom_range(full - 1));
      end else if (pick < 88) begin
        start_shape(circle, pick_coord(ScreenWidth), pick_coord(ScreenHeight), $urandom,
                    $urandom, 4'($urandom), 4'($urandom), 4'($urandom));
        send_ticks($urandom_range(6, 1));
      end else if (pick < 95) begin
        if (circle) a = 0;
        else if ($urandom_range(1)) a = 0;
        else b = 0;
        start_shape(circle, pick_coord(ScreenWidth), pick_coord(ScreenHeight), a, b,
                    4'($urandom), 4'($urandom), 4'($urandom));
        send_ticks(1);
      end else begin
        send_ticks($urandom_range(3, 1));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part runs on the reset frame base
    send_ticks(1);
    start_shape(1'b0, 0, 0, 2, 2, 4'hf, 4'h0, 4'hf);
    send_ticks(4);
    start_shape(1'b0, 100, 100, 0, 5, 4'h1, 4'h2, 4'h3);
    send_ticks(1);
    start_shape(1'b0, 100, 100, 5, 0, 4'h1, 4'h2, 4'h3);
    start_shape(1'b1, 50, 50, 0, 7, 4'h5, 4'h6, 4'h7);
    send_ticks(1);
    start_shape(1'b1, 0, 0, 1, 0, 4'h0, 4'h0, 4'h0);
    send_ticks(4);
    start_shape(1'b0, ScreenWidth - 1, ScreenHeight - 1, 2, 1, 4'hf, 4'hf, 4'hf);
    send_ticks(2);
    start_shape(1'b0, -2048, -2048, 2047, 2047, 4'ha, 4'h5, 4'ha);
    send_ticks(2);
    // a start while busy abandons the big rectangle, and later this circle
    start_shape(1'b1, 2047, 2047, 2047, 2047, 4'h5, 4'ha, 4'h5);
    send_ticks(2);
    drain_results();

    set_frame_base('0);
    random_phase(PhaseItems, 1'b0);
    drain_results();
    set_frame_base('1);
    random_phase(PhaseItems, 1'b1);
    drain_results();
    set_frame_base(frs_pkg::AddrW'($urandom));
    random_phase(PhaseItems, 1'b0);
    drain_results();
    set_frame_base(30'h3fff_fc00);
    random_phase(PhaseItems, 1'b0);
    drain_results();

    if (sb.errors == 0) begin
      $display("PASS filled_shape_rasterizer_unit");
    end else begin
      $display("FAIL filled_shape_rasterizer_unit");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/frs_pkg.sv
rtl/core/frs_cfg_regs.sv
rtl/core/frs_scanner.sv
rtl/core/frs_pixel.sv
rtl/core/filled_shape_rasterizer_unit.sv
tb/sv/filled_shape_rasterizer_unit_test.sv
